@@ design/nme_pkg.sv @@
// Shared constants, codes and the xorshift step for the netlist mutation engine.
`default_nettype none
package nme_pkg;
    localparam int MAX_GATES_DEF = 256;
    localparam int MAX_ROOTS_DEF = 8;

    localparam int DRAW_W = 31;
    localparam int STEP_W = $clog2(DRAW_W);

    localparam int ROLL_RANGE = 100;
    localparam int ADD_LIMIT  = 75;
    localparam int KIND_RANGE = 7;

    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_MUTATE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    localparam logic [1:0] MK_ADDED   = 2'd0;
    localparam logic [1:0] MK_REMOVED = 2'd1;
    localparam logic [1:0] MK_FULL    = 2'd2;
    localparam logic [1:0] MK_NONE    = 2'd3;

    localparam logic [1:0] CFG_INPUT_COUNT = 2'd0;
    localparam logic [1:0] CFG_ROOT_COUNT  = 2'd1;
    localparam logic [1:0] CFG_PRNG_SEED   = 2'd2;

    function automatic logic [31:0] nme_xs(input logic [31:0] x);
        logic [31:0] y;
        y = x ^ (x << 13);
        y = y ^ (y >> 17);
        y = y ^ (y << 5);
        return y;
    endfunction
endpackage
`default_nettype wire

@@ design/netlist_mutation_engine_core.sv @@
// Netlist mutation engine: gate table, root set and mutation sequencer.
//
// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_stall         i_operation, i_read_index
// result    out        o_valid / i_stall         o_mutation_kind .. o_last
// config    in         i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// Each random draw runs through the shared bit-serial modulo unit.
// Mutate: 1 to 4 draws, a renumber pass over the non-input gates on removal,
// then one draw per root plus redraws.
// Clear sweeps the input entries of the table, one per cycle;
// reset runs the same sweep with two entries. A read registers the entry in S_RD before S_OUT.
// One item at a time: o_stall stays high until the last result has transferred.
`default_nettype none
module netlist_mutation_engine_core import nme_pkg::*; #(
    parameter int MAX_GATES = MAX_GATES_DEF,
    parameter int MAX_ROOTS = MAX_ROOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [7:0]  i_read_index,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic      [1:0]  o_mutation_kind,
    output logic      [8:0]  o_gate_count,
    output logic      [2:0]  o_root_slot,
    output logic      [7:0]  o_root_index,
    output logic      [2:0]  o_entry_kind,
    output logic      [7:0]  o_entry_a,
    output logic      [7:0]  o_entry_b,
    output logic             o_last,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    localparam int IW  = $clog2(MAX_GATES);
    localparam int CW  = $clog2(MAX_GATES + 1);
    localparam int DW  = (CW > 7) ? CW : 7;
    localparam int NW  = (CW > 9) ? CW : 9;
    localparam int EW  = 3 + 2 * IW;
    localparam int RL  = (MAX_ROOTS < 8) ? MAX_ROOTS : 8;
    localparam int RIW = (RL > 1) ? $clog2(RL) : 1;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_ROLL, S_KIND, S_OPA, S_OPB, S_PT, S_REN,
        S_RSEL, S_ROOT, S_RD, S_OUT
    } t_state;

    t_state          r_state;
    logic [8:0]      r_cfg_nin;
    logic [3:0]      r_cfg_roots;
    logic [31:0]     r_cfg_seed;
    logic [31:0]     r_prng;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   r_ci;
    logic            r_emit;
    logic            r_mut;
    logic [1:0]      r_okind;
    logic [3:0]      r_nroots;
    logic [3:0]      r_k;
    logic [IW-1:0]   r_root [RL];
    logic [2:0]      r_nk;
    logic [IW-1:0]   r_na;
    logic [CW-1:0]   r_pt;
    logic [CW-1:0]   r_ri;
    logic [CW-1:0]   r_wi;
    logic            r_pv;
    logic [2:0]      r_ek;
    logic [7:0]      r_ea;
    logic [7:0]      r_eb;

    logic [31:0]     w_xs;
    logic            w_dstart;
    logic [DW-1:0]   w_divisor;
    logic            w_ddone;
    logic [DW-1:0]   w_rem;
    logic [CW-1:0]   w_nin;
    logic [3:0]      w_nroots;
    logic            w_we;
    logic [IW-1:0]   w_waddr;
    logic [EW-1:0]   w_wdata;
    logic [IW-1:0]   w_raddr;
    logic [EW-1:0]   w_rdata;
    logic [IW-1:0]   w_ra;
    logic [IW-1:0]   w_rb;
    logic [RIW-1:0]  w_kidx;
    logic            w_req;
    logic            w_accept;

    assign w_xs     = nme_xs(r_prng);
    assign w_kidx   = r_k[RIW-1:0];
    assign w_req    = (CW'(w_rem) == CW'(r_root[w_kidx]));
    assign w_accept = i_valid && (r_state == S_IDLE);

    // Effective register values after clamping
    always_comb begin
        if (r_cfg_nin == '0) begin
            w_nin = CW'(1);
        end else if (NW'(r_cfg_nin) > NW'(MAX_GATES)) begin
            w_nin = CW'(MAX_GATES);
        end else begin
            w_nin = CW'(r_cfg_nin);
        end
        if (r_cfg_roots == '0) begin
            w_nroots = 4'd1;
        end else if (r_cfg_roots > 4'(RL)) begin
            w_nroots = 4'(RL);
        end else begin
            w_nroots = r_cfg_roots;
        end
    end

    // Draw requests to the modulo unit
    always_comb begin
        w_dstart  = 1'b0;
        w_divisor = DW'(r_count);
        unique case (r_state)
            S_IDLE: begin
                w_dstart  = w_accept && (i_operation == OP_MUTATE);
                w_divisor = DW'(ROLL_RANGE);
            end
            S_ROLL: begin
                if (w_rem <= DW'(ADD_LIMIT)) begin
                    w_dstart  = w_ddone && (r_count < CW'(MAX_GATES));
                    w_divisor = DW'(KIND_RANGE);
                end else begin
                    w_dstart  = w_ddone && (r_count > w_nin);
                    w_divisor = DW'(r_count - w_nin);
                end
            end
            S_KIND, S_OPA: w_dstart = w_ddone;
            S_RSEL:        w_dstart = (r_count > CW'(1));
            S_ROOT:        w_dstart = w_ddone && (w_req || (r_k + 4'd1 != r_nroots));
            default:       w_dstart = 1'b0;
        endcase
    end

    // Renumbered operands of the entry in flight
    always_comb begin
        w_ra = w_rdata[2*IW-1:IW];
        w_rb = w_rdata[IW-1:0];
        if (CW'(w_ra) >= r_pt) begin
            w_ra = w_ra - 1'b1;
        end
        if (CW'(w_rb) >= r_pt) begin
            w_rb = w_rb - 1'b1;
        end
    end

    // Table port control
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ci[IW-1:0];
        w_wdata = '0;
        w_raddr = (r_state == S_IDLE) ? IW'(i_read_index) : r_ri[IW-1:0];
        unique case (r_state)
            S_CLR: begin
                w_we = (r_ci < r_count);
            end
            S_OPB: begin
                w_we    = w_ddone;
                w_waddr = r_count[IW-1:0];
                w_wdata = {r_nk, r_na, IW'(w_rem)};
            end
            S_REN: begin
                w_wdata = {w_rdata[EW-1:2*IW], w_ra, w_rb};
                if (r_pv && (r_wi < r_pt)) begin
                    w_we    = 1'b1;
                    w_waddr = r_wi[IW-1:0];
                end else if (r_pv && (r_wi > r_pt)) begin
                    w_we    = 1'b1;
                    w_waddr = IW'(r_wi - 1'b1);
                end
            end
            default: w_we = 1'b0;
        endcase
    end

    nme_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_GATES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    nme_modu #(
        .DW (DW)
    ) u_modu (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_dstart),
        .i_dividend (w_xs[31:1]),
        .i_divisor  (w_divisor),
        .o_done     (w_ddone),
        .o_rem      (w_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_cfg_nin   <= 9'd2;
            r_cfg_roots <= 4'd1;
            r_cfg_seed  <= 32'd1;
            r_prng      <= 32'd1;
            r_count     <= CW'(2);
            r_ci        <= '0;
            r_emit      <= 1'b0;
            r_mut       <= 1'b0;
            r_okind     <= MK_NONE;
            r_nroots    <= 4'd1;
            r_k         <= '0;
            r_pv        <= 1'b0;
            for (int j = 0; j < RL; j++) begin
                r_root[j] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_INPUT_COUNT: r_cfg_nin   <= i_cfg_data[8:0];
                    CFG_ROOT_COUNT:  r_cfg_roots <= i_cfg_data[3:0];
                    CFG_PRNG_SEED:   r_cfg_seed  <= i_cfg_data;
                    default:         r_cfg_seed  <= r_cfg_seed;
                endcase
            end
            if (w_dstart) begin
                r_prng <= w_xs;
            end
            unique case (r_state)
                S_CLR: begin
                    if (r_ci < r_count) begin
                        r_ci <= r_ci + 1'b1;
                    end else begin
                        r_state <= r_emit ? S_OUT : S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_mut    <= 1'b0;
                        r_okind  <= MK_NONE;
                        r_k      <= '0;
                        r_ek     <= '0;
                        r_ea     <= '0;
                        r_eb     <= '0;
                        r_nroots <= w_nroots;
                        priority if (i_operation == OP_CLEAR) begin
                            r_count <= w_nin;
                            r_prng  <= (r_cfg_seed == '0) ? 32'd1 : r_cfg_seed;
                            r_ci    <= '0;
                            r_emit  <= 1'b1;
                            for (int j = 0; j < RL; j++) begin
                                r_root[j] <= '0;
                            end
                            r_state <= S_CLR;
                        end else if (i_operation == OP_MUTATE) begin
                            r_mut   <= 1'b1;
                            r_state <= S_ROLL;
                        end else if ((i_operation == OP_READ)
                                     && (NW'(i_read_index) < NW'(r_count))) begin
                            r_state <= S_RD;
                        end else begin
                            r_state <= S_OUT;
                        end
                    end
                end
                S_ROLL: begin
                    if (w_ddone) begin
                        if (w_rem <= DW'(ADD_LIMIT)) begin
                            if (r_count >= CW'(MAX_GATES)) begin
                                r_okind <= MK_FULL;
                                r_state <= S_RSEL;
                            end else begin
                                r_state <= S_KIND;
                            end
                        end else if (r_count <= w_nin) begin
                            r_okind <= MK_NONE;
                            r_state <= S_RSEL;
                        end else begin
                            r_state <= S_PT;
                        end
                    end
                end
                S_KIND: begin
                    if (w_ddone) begin
                        r_nk    <= 3'(w_rem) + 3'd1;
                        r_state <= S_OPA;
                    end
                end
                S_OPA: begin
                    if (w_ddone) begin
                        r_na    <= IW'(w_rem);
                        r_state <= S_OPB;
                    end
                end
                S_OPB: begin
                    if (w_ddone) begin
                        r_count <= r_count + 1'b1;
                        r_okind <= MK_ADDED;
                        r_state <= S_RSEL;
                    end
                end
                S_PT: begin
                    if (w_ddone) begin
                        r_pt    <= CW'(w_rem) + w_nin;
                        r_ri    <= w_nin;
                        r_pv    <= 1'b0;
                        r_state <= S_REN;
                    end
                end
                S_REN: begin
                    // read one entry ahead of the write-back
                    if (r_ri < r_count) begin
                        r_ri <= r_ri + 1'b1;
                        r_wi <= r_ri;
                        r_pv <= 1'b1;
                    end else begin
                        r_pv <= 1'b0;
                        if (!r_pv) begin
                            r_count <= r_count - 1'b1;
                            r_okind <= MK_REMOVED;
                            r_state <= S_RSEL;
                        end
                    end
                end
                S_RSEL: begin
                    r_k     <= '0;
                    r_state <= (r_count > CW'(1)) ? S_ROOT : S_OUT;
                end
                S_ROOT: begin
                    if (w_ddone && !w_req) begin
                        r_root[w_kidx] <= IW'(w_rem);
                        if (r_k + 4'd1 == r_nroots) begin
                            r_k     <= '0;
                            r_state <= S_OUT;
                        end else begin
                            r_k <= r_k + 4'd1;
                        end
                    end
                end
                S_RD: begin
                    r_ek    <= w_rdata[EW-1:2*IW];
                    r_ea    <= 8'(w_rdata[2*IW-1:IW]);
                    r_eb    <= 8'(w_rdata[IW-1:0]);
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!i_stall) begin
                        if (!r_mut || (r_k + 4'd1 == r_nroots)) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + 4'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall         = (r_state != S_IDLE);
    assign o_cfg_ready     = 1'b1;
    assign o_valid         = (r_state == S_OUT);
    assign o_mutation_kind = r_okind;
    assign o_gate_count    = 9'(r_count);
    assign o_root_slot     = r_mut ? 3'(r_k) : 3'd0;
    assign o_root_index    = r_mut ? 8'(r_root[w_kidx]) : 8'd0;
    assign o_entry_kind    = r_ek;
    assign o_entry_a       = r_ea;
    assign o_entry_b       = r_eb;
    assign o_last          = !r_mut || (r_k + 4'd1 == r_nroots);
endmodule
`default_nettype wire

@@ design/nme_ram.sv @@
// Generic simple dual-port RAM with registered read.
`default_nettype none
module nme_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ design/nme_modu.sv @@
// Bit-serial restoring modulo unit: 31-bit draw modulo a narrow divisor.
`default_nettype none
module nme_modu import nme_pkg::*; #(
    parameter int DW = 9
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DRAW_W-1:0] i_dividend,
    input  wire logic [DW-1:0]     i_divisor,
    output logic                   o_done,
    output logic      [DW-1:0]     o_rem
);
    logic              r_busy;
    logic [STEP_W-1:0] r_cnt;
    logic [DRAW_W-1:0] r_q;
    logic [DW-1:0]     r_d;
    logic [DW:0]       w_t;

    assign w_t = {o_rem, r_q[DRAW_W-1]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEP_W'(DRAW_W - 1);
                r_q    <= i_dividend;
                r_d    <= i_divisor;
                o_rem  <= '0;
            end else if (r_busy) begin
                r_q <= r_q << 1;
                if (w_t >= {1'b0, r_d}) begin
                    o_rem <= DW'(w_t - {1'b0, r_d});
                end else begin
                    o_rem <= w_t[DW-1:0];
                end
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end
endmodule
`default_nettype wire

@@ dv/nme_checker.sv @@
// Checker for the netlist mutation engine: tracks the handshakes, predicts results and compares.
`timescale 1ns / 1ps
module nme_checker import nme_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [1:0]  i_operation,
    input  wire logic [7:0]  i_read_index,
    input  wire logic        i_out_valid,
    input  wire logic        i_out_stall,
    input  wire logic [1:0]  i_mutation_kind,
    input  wire logic [8:0]  i_gate_count,
    input  wire logic [2:0]  i_root_slot,
    input  wire logic [7:0]  i_root_index,
    input  wire logic [2:0]  i_entry_kind,
    input  wire logic [7:0]  i_entry_a,
    input  wire logic [7:0]  i_entry_b,
    input  wire logic        i_last,
    input  wire logic        i_cfg_valid,
    input  wire logic        i_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output int               o_fail_count,
    output int               o_pending
);
    typedef struct packed {
        logic [1:0] kind;
        logic [8:0] count;
        logic [2:0] slot;
        logic [7:0] root;
        logic [2:0] ek;
        logic [7:0] ea;
        logic [7:0] eb;
        logic       last;
    } t_netlist_result;

    t_netlist_result result_fifo[$];

    logic [2:0]  gate_kind[256];
    logic [7:0]  gate_a[256];
    logic [7:0]  gate_b[256];
    logic [8:0]  gate_total;
    logic [7:0]  root_sel[8];
    logic [31:0] xs_state;
    logic [8:0]  cfg_inputs;
    logic [3:0]  cfg_roots;
    logic [31:0] cfg_seed;
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = result_fifo.size();

    function automatic int unsigned clamped_inputs();
        if (cfg_inputs < 1) return 1;
        if (cfg_inputs > 256) return 256;
        return cfg_inputs;
    endfunction

    function automatic int unsigned clamped_roots();
        if (cfg_roots < 1) return 1;
        if (cfg_roots > 8) return 8;
        return cfg_roots;
    endfunction

    task automatic next_rand(output int unsigned r);
        logic [31:0] x;
        x = xs_state;
        x = x ^ (x << 13);
        x = x ^ (x >> 17);
        x = x ^ (x << 5);
        xs_state = x;
        r = x >> 1;
    endtask

    task automatic clear_netlist();
        for (int i = 0; i < 256; i++) begin
            gate_kind[i] = '0;
            gate_a[i] = '0;
            gate_b[i] = '0;
        end
        for (int i = 0; i < 8; i++) root_sel[i] = '0;
        gate_total = 9'(clamped_inputs());
        xs_state = (cfg_seed == 0) ? 32'd1 : cfg_seed;
    endtask

    task automatic mutate_netlist(output logic [1:0] mk);
        int unsigned nin, roll, n, r, pt, nr;
        nin = clamped_inputs();
        next_rand(r);
        roll = r % 100;
        n = gate_total;
        if (roll <= 75) begin
            if (n >= 256) begin
                mk = MK_FULL;
            end else begin
                next_rand(r);
                gate_kind[n] = 3'(r % 7 + 1);
                next_rand(r);
                gate_a[n] = 8'(r % n);
                next_rand(r);
                gate_b[n] = 8'(r % n);
                gate_total = 9'(n + 1);
                mk = MK_ADDED;
            end
        end else if (n <= nin) begin
            mk = MK_NONE;
        end else begin
            next_rand(r);
            pt = r % (n - nin) + nin;
            for (int unsigned i = nin; i < n; i++) begin
                if (gate_a[i] >= pt) gate_a[i] = gate_a[i] - 8'd1;
                if (gate_b[i] >= pt) gate_b[i] = gate_b[i] - 8'd1;
            end
            for (int unsigned i = pt; i + 1 < n; i++) begin
                gate_kind[i] = gate_kind[i+1];
                gate_a[i] = gate_a[i+1];
                gate_b[i] = gate_b[i+1];
            end
            gate_total = 9'(n - 1);
            mk = MK_REMOVED;
        end
        // roots are redrawn whatever happened to the table, if more than one gate remains
        if (gate_total > 1) begin
            for (int k = 0; k < clamped_roots(); k++) begin
                do begin
                    next_rand(r);
                    nr = r % gate_total;
                end while (nr == root_sel[k]);
                root_sel[k] = 8'(nr);
            end
        end
    endtask

    task automatic predict_item(input logic [1:0] op, input logic [7:0] idx);
        t_netlist_result res;
        logic [1:0] mk;
        int unsigned nroots;
        res = '0;
        res.kind = MK_NONE;
        res.last = 1'b1;
        if (op == OP_CLEAR) begin
            clear_netlist();
            res.count = gate_total;
            result_fifo.push_back(res);
        end else if (op == OP_MUTATE) begin
            nroots = clamped_roots();
            mutate_netlist(mk);
            for (int k = 0; k < nroots; k++) begin
                res.kind = mk;
                res.count = gate_total;
                res.slot = 3'(k);
                res.root = root_sel[k];
                res.last = (k + 1 == nroots);
                result_fifo.push_back(res);
            end
        end else begin
            res.count = gate_total;
            if (op == OP_READ && idx < gate_total) begin
                res.ek = gate_kind[idx];
                res.ea = gate_a[idx];
                res.eb = gate_b[idx];
            end
            result_fifo.push_back(res);
        end
    endtask

    task automatic check_result();
        t_netlist_result e;
        if (result_fifo.size() == 0) begin
            $error("result transfer with nothing expected");
            fails++;
            return;
        end
        e = result_fifo.pop_front();
        if (i_mutation_kind !== e.kind) begin
            $error("mutation_kind exp %0d got %0d", e.kind, i_mutation_kind); fails++;
        end
        if (i_gate_count !== e.count) begin
            $error("gate_count exp %0d got %0d", e.count, i_gate_count); fails++;
        end
        if (i_root_slot !== e.slot) begin
            $error("root_slot exp %0d got %0d", e.slot, i_root_slot); fails++;
        end
        if (i_root_index !== e.root) begin
            $error("root_index exp %0d got %0d", e.root, i_root_index); fails++;
        end
        if (i_entry_kind !== e.ek) begin
            $error("entry_kind exp %0d got %0d", e.ek, i_entry_kind); fails++;
        end
        if (i_entry_a !== e.ea) begin
            $error("entry_a exp %0d got %0d", e.ea, i_entry_a); fails++;
        end
        if (i_entry_b !== e.eb) begin
            $error("entry_b exp %0d got %0d", e.eb, i_entry_b); fails++;
        end
        if (i_last !== e.last) begin
            $error("last exp %0d got %0d", e.last, i_last); fails++;
        end
    endtask

    initial fails = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg_inputs = 9'd2;
            cfg_roots = 4'd1;
            cfg_seed = 32'd1;
            clear_netlist();
            result_fifo.delete();
        end else begin
            if (i_out_valid && !i_out_stall) check_result();
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_INPUT_COUNT: cfg_inputs = i_cfg_data[8:0];
                    CFG_ROOT_COUNT:  cfg_roots = i_cfg_data[3:0];
                    CFG_PRNG_SEED:   cfg_seed = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) predict_item(i_operation, i_read_index);
        end
    end
endmodule

@@ dv/tb_netlist_mutation_engine_core.sv @@
// Testbench top for the netlist mutation engine: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module tb_netlist_mutation_engine_core;
    import nme_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int HOLD_CYCLES = 700;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic [1:0]  i_operation = 0;
    logic [7:0]  i_read_index = 0;
    logic        i_stall = 0;
    logic        i_cfg_valid = 0;
    logic [1:0]  i_cfg_index = 0;
    logic [31:0] i_cfg_data = 0;
    wire         o_stall, o_valid, o_last, o_cfg_ready;
    wire  [1:0]  o_mutation_kind;
    wire  [8:0]  o_gate_count;
    wire  [2:0]  o_root_slot, o_entry_kind;
    wire  [7:0]  o_root_index, o_entry_a, o_entry_b;
    int          fail_count, pending;

    int          send_idle_pct = 33;
    int          recv_idle_pct = 85;
    bit          hold_req = 0;
    bit          hold_seen = 0;
    int          hold_left = 0;
    int          cycle_no = 0;

    netlist_mutation_engine_core uut (.*);

    nme_checker chk (
        .i_clk, .i_rst_n,
        .i_in_valid(i_valid), .i_in_stall(o_stall),
        .i_operation, .i_read_index,
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_mutation_kind(o_mutation_kind), .i_gate_count(o_gate_count),
        .i_root_slot(o_root_slot), .i_root_index(o_root_index),
        .i_entry_kind(o_entry_kind), .i_entry_a(o_entry_a), .i_entry_b(o_entry_b),
        .i_last(o_last),
        .i_cfg_valid, .i_cfg_ready(o_cfg_ready), .i_cfg_index, .i_cfg_data,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // receiver pacing, with one long hold-off on request
    always @(posedge i_clk) begin
        if (hold_req && !hold_seen) begin
            hold_seen <= 1;
            hold_left <= HOLD_CYCLES;
            i_stall <= 1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_stall <= 1;
        end else begin
            i_stall <= ($urandom % 100) < recv_idle_pct;
        end
    end

    always @(posedge i_clk) begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > CYCLE_LIMIT) begin
            $display("netlist_mutation_engine_core test failed");
            $finish;
        end
    end

    task automatic send_item(input logic [1:0] op, input logic [7:0] idx);
        while (($urandom % 100) < send_idle_pct) begin
            i_valid <= 0;
            @(posedge i_clk);
        end
        i_valid <= 1;
        i_operation <= op;
        i_read_index <= idx;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic drain();
        i_valid <= 0;
        do @(posedge i_clk); while (pending != 0);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    task automatic setup(input logic [8:0] ic, input logic [3:0] rc, input logic [31:0] seed);
        drain();
        write_reg(CFG_INPUT_COUNT, 32'(ic));
        write_reg(CFG_ROOT_COUNT, 32'(rc));
        write_reg(CFG_PRNG_SEED, seed);
        send_item(OP_CLEAR, 8'd0);
    endtask

    task automatic random_items(input int n);
        int r;
        logic [7:0] idx;
        for (int i = 0; i < n; i++) begin
            r = $urandom % 100;
            idx = ($urandom % 4 == 0) ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, 24));
            if (r < 60)      send_item(OP_MUTATE, idx);
            else if (r < 88) send_item(OP_READ, idx);
            else if (r < 94) send_item(OP_CLEAR, idx);
            else             send_item(2'd3, idx);
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // defaults after reset: reads of inputs, out-of-range read, bad op, mutates, reads of new gates, clear
        send_item(OP_READ, 8'd0);
        send_item(OP_READ, 8'd1);
        send_item(OP_READ, 8'd255);
        send_item(2'd3, 8'hAA);
        repeat (6) send_item(OP_MUTATE, 8'h55);
        send_item(OP_READ, 8'd2);
        send_item(OP_READ, 8'd3);
        send_item(OP_CLEAR, 8'd0);

        // single input, zero seed, all roots
        setup(9'd0, 4'd8, 32'd0);
        random_items(80);
        setup(9'd3, 4'd15, 32'hFFFF_FFFF);
        hold_req <= 1;
        random_items(85);

        send_idle_pct = 85;
        recv_idle_pct = 33;
        // whole table of inputs: adds skipped, removes have nothing to do
        setup(9'd511, 4'd0, $urandom);
        repeat (4) send_item(OP_MUTATE, 8'd0);
        send_item(OP_READ, 8'd255);
        // fill to the top
        setup(9'd254, 4'd2, $urandom);
        repeat (8) send_item(OP_MUTATE, 8'd0);
        send_item(OP_READ, 8'd255);
        setup(9'($urandom_range(1, 6)), 4'($urandom_range(1, 8)), $urandom);
        random_items(80);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        setup(9'($urandom_range(1, 6)), 4'($urandom_range(1, 8)), $urandom);
        random_items(95);
        setup(9'($urandom_range(1, 4)), 4'($urandom_range(1, 8)), $urandom);
        random_items(90);
        setup(9'd256, 4'd1, $urandom);
        repeat (3) send_item(OP_MUTATE, 8'd0);

        drain();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("netlist_mutation_engine_core test passed");
        end else begin
            $display("netlist_mutation_engine_core test failed");
        end
        $finish;
    end
endmodule
